// ===== design/ieea_pkg.sv =====
// Shared types and constants for the indexed insert/erase array.
// Used by ieea_cell, ieea_ctrl and indexed_insert_erase_array; no dependencies.
`timescale 1ns / 1ps

package ieea_pkg;

   localparam int DEPTH     = 64;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int CALC_BITS = ((CNT_BITS > 7) ? CNT_BITS : 7) + 1;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CALC_BITS-1:0] calc_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   localparam logic [3:0] OP_PUSH        = 4'd0;
   localparam logic [3:0] OP_POP         = 4'd1;
   localparam logic [3:0] OP_INSERT      = 4'd2;
   localparam logic [3:0] OP_INSERT_N    = 4'd3;
   localparam logic [3:0] OP_ERASE       = 4'd4;
   localparam logic [3:0] OP_ERASE_RANGE = 4'd5;
   localparam logic [3:0] OP_RESIZE      = 4'd6;
   localparam logic [3:0] OP_RESIZE_FILL = 4'd7;
   localparam logic [3:0] OP_ASSIGN      = 4'd8;
   localparam logic [3:0] OP_CLEAR       = 4'd9;
   localparam logic [3:0] OP_READ        = 4'd10;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [3:0]  op;
      logic [6:0]  index;
      logic [6:0]  amount;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [6:0]  fill_count;
      logic [1:0]  status;
      logic [6:0]  result_position;
   } rsp_type;

   typedef enum logic [1:0] {
      SRC_LOWER   = 2'd0,
      SRC_UPPER   = 2'd1,
      SRC_TRANSIT = 2'd2
   } src_type;

   typedef enum logic [2:0] {
      TR_HOLD       = 3'd0,
      TR_LOAD_LOWER = 3'd1,
      TR_LOAD_UPPER = 3'd2,
      TR_LOWER      = 3'd3,
      TR_UPPER      = 3'd4
   } transit_type;

   // Each cell writes the fill word when its position lies in [fill_lo, fill_hi),
   // otherwise takes the selected source when it lies in [move_lo, move_hi).
   typedef struct packed {
      calc_type    fill_lo;
      calc_type    fill_hi;
      calc_type    move_lo;
      calc_type    move_hi;
      src_type     src;
      transit_type tmode;
      word_type    fill_word;
   } cell_ctrl_type;

endpackage

// ===== design/ieea_cell.sv =====
// One storage cell of the array: a stored word and a transit word for multi-step shifts.
// Depends on ieea_pkg.
`timescale 1ns / 1ps

module ieea_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ieea_pkg::IDX_BITS-1:0] cell_index,
   input  ieea_pkg::cell_ctrl_type ctrl,
   input  ieea_pkg::word_type      lower_word,
   input  ieea_pkg::word_type      upper_word,
   input  ieea_pkg::word_type      lower_transit,
   input  ieea_pkg::word_type      upper_transit,
   output ieea_pkg::word_type      word,
   output ieea_pkg::word_type      transit
);
   import ieea_pkg::*;

   word_type word_ff, word_in;
   word_type transit_ff, transit_in;
   calc_type pos;
   logic     in_fill, in_move;
   word_type src_word;

   always_comb begin
      pos     = CALC_BITS'(cell_index);
      in_fill = (pos >= ctrl.fill_lo) && (pos < ctrl.fill_hi);
      in_move = (pos >= ctrl.move_lo) && (pos < ctrl.move_hi);
      case (ctrl.src)
         SRC_LOWER:   src_word = lower_word;
         SRC_UPPER:   src_word = upper_word;
         SRC_TRANSIT: src_word = transit_ff;
         default:     src_word = word_ff;
      endcase
      if (in_fill) begin
         word_in = ctrl.fill_word;
      end else if (in_move) begin
         word_in = src_word;
      end else begin
         word_in = word_ff;
      end
      case (ctrl.tmode)
         TR_LOAD_LOWER: transit_in = lower_word;
         TR_LOAD_UPPER: transit_in = upper_word;
         TR_LOWER:      transit_in = lower_transit;
         TR_UPPER:      transit_in = upper_transit;
         default:       transit_in = transit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
      transit_ff <= transit_in;
   end

   assign word    = word_ff;
   assign transit = transit_ff;

endmodule

// ===== design/ieea_ctrl.sv =====
// Operation decoder, fill count, shift sequencer and result register.
// Depends on ieea_pkg; drives the control word shared by all ieea_cell instances.
`timescale 1ns / 1ps

module ieea_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ieea_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ieea_pkg::rsp_type       rsp_data,
   input  ieea_pkg::word_type      cell_word [ieea_pkg::DEPTH],
   output ieea_pkg::cell_ctrl_type cell_ctrl
);
   import ieea_pkg::*;

   typedef enum logic [2:0] {
      SEQ_IDLE   = 3'b001,
      SEQ_SHIFT  = 3'b010,
      SEQ_COMMIT = 3'b100
   } seq_type;

   localparam calc_type DEPTH_C = CALC_BITS'(DEPTH);

   seq_type       state_ff, state_in;
   cnt_type       count_ff, count_in;
   cnt_type       step_ff, step_in;
   logic          down_ff, down_in;
   cell_ctrl_type pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   cell_ctrl_type idle_ctrl, dec_ctrl;
   calc_type      c, i, a, m, new_c;
   logic [1:0]    st;
   word_type      val, rd;
   logic          multi, accept;

   assign req_stall = (state_ff != SEQ_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      idle_ctrl           = '0;
      idle_ctrl.src       = SRC_LOWER;
      idle_ctrl.tmode     = TR_HOLD;
      c     = CALC_BITS'(count_ff);
      i     = CALC_BITS'(req_data.index);
      a     = CALC_BITS'(req_data.amount);
      val   = WORD_BITS'(req_data.write_value);
      new_c = c;
      st    = ST_OK;
      rd    = '0;
      m     = '0;
      multi = 1'b0;
      dec_ctrl = idle_ctrl;
      dec_ctrl.fill_word = val;
      pend_in  = idle_ctrl;
      pend_in.src       = SRC_TRANSIT;
      pend_in.fill_word = val;
      down_in  = down_ff;
      case (req_data.op)
         OP_PUSH: begin
            if (c >= DEPTH_C) begin
               st = ST_FULL;
            end else begin
               dec_ctrl.fill_lo = c;
               dec_ctrl.fill_hi = c + 1'b1;
               new_c = c + 1'b1;
            end
         end
         OP_POP: begin
            if (c == '0) begin
               st = ST_EMPTY;
            end else begin
               new_c = c - 1'b1;
            end
         end
         OP_INSERT: begin
            if (i > c) begin
               st = ST_RANGE;
            end else if (c + 1'b1 > DEPTH_C) begin
               st = ST_FULL;
            end else begin
               dec_ctrl.fill_lo = i;
               dec_ctrl.fill_hi = i + 1'b1;
               dec_ctrl.move_lo = i + 1'b1;
               dec_ctrl.move_hi = c + 1'b1;
               dec_ctrl.src     = SRC_LOWER;
               new_c = c + 1'b1;
            end
         end
         OP_INSERT_N: begin
            if (i > c) begin
               st = ST_RANGE;
            end else if (c + a > DEPTH_C) begin
               st = ST_FULL;
            end else begin
               m     = a;
               multi = (a != '0);
               new_c = c + a;
               pend_in.fill_lo = i;
               pend_in.fill_hi = i + a;
               pend_in.move_lo = i + a;
               pend_in.move_hi = c + a;
               dec_ctrl.tmode  = multi ? TR_LOAD_LOWER : TR_HOLD;
               down_in = 1'b0;
            end
         end
         OP_ERASE: begin
            if (c == '0) begin
               st = ST_EMPTY;
            end else if (i >= c) begin
               st = ST_RANGE;
            end else begin
               dec_ctrl.move_lo = i;
               dec_ctrl.move_hi = c - 1'b1;
               dec_ctrl.src     = SRC_UPPER;
               new_c = c - 1'b1;
            end
         end
         OP_ERASE_RANGE: begin
            if ((i > a) || (a > c)) begin
               st = ST_RANGE;
            end else begin
               m     = a - i;
               multi = (a != i);
               new_c = c - (a - i);
               pend_in.move_lo = i;
               pend_in.move_hi = c - (a - i);
               dec_ctrl.tmode  = multi ? TR_LOAD_UPPER : TR_HOLD;
               down_in = 1'b1;
            end
         end
         OP_RESIZE: begin
            if (a > DEPTH_C) begin
               st = ST_FULL;
            end else begin
               new_c = a;
            end
         end
         OP_RESIZE_FILL: begin
            if (a > DEPTH_C) begin
               st = ST_FULL;
            end else begin
               dec_ctrl.fill_lo = c;
               dec_ctrl.fill_hi = a;
               new_c = a;
            end
         end
         OP_ASSIGN: begin
            if (a > DEPTH_C) begin
               st = ST_FULL;
            end else begin
               dec_ctrl.fill_lo = '0;
               dec_ctrl.fill_hi = a;
               new_c = a;
            end
         end
         OP_CLEAR: begin
            new_c = '0;
         end
         OP_READ: begin
            if (i >= c) begin
               st = ST_RANGE;
            end else begin
               rd = cell_word[IDX_BITS'(i)];
            end
         end
         default: begin
            new_c = c;
         end
      endcase

      rsp_in.read_value      = 32'(rd);
      rsp_in.fill_count      = 7'(new_c);
      rsp_in.status          = st;
      rsp_in.result_position = ((st == ST_OK) && ((req_data.op == OP_INSERT) ||
                                (req_data.op == OP_INSERT_N) || (req_data.op == OP_ERASE) ||
                                (req_data.op == OP_ERASE_RANGE))) ? 7'(i) : 7'd0;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cell_ctrl    = idle_ctrl;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               cell_ctrl = dec_ctrl;
               count_in  = CNT_BITS'(new_c);
               if (multi) begin
                  step_in  = CNT_BITS'(m - 1'b1);
                  state_in = (m == calc_type'(1)) ? SEQ_COMMIT : SEQ_SHIFT;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         SEQ_SHIFT: begin
            cell_ctrl.tmode = down_ff ? TR_UPPER : TR_LOWER;
            step_in = step_ff - 1'b1;
            if (step_ff == cnt_type'(1)) begin
               state_in = SEQ_COMMIT;
            end
         end
         SEQ_COMMIT: begin
            cell_ctrl    = pend_ff;
            rsp_valid_in = 1'b1;
            state_in     = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
      if (accept) begin
         rsp_ff  <= rsp_in;
         pend_ff <= pend_in;
         down_ff <= down_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      CALC_BITS'(count_ff) <= DEPTH_C)
      else $error("fill count above capacity");

   a_busy_no_rsp : assert property (@(posedge clock) disable iff (reset)
      (state_ff != SEQ_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while a shift is in progress");

   a_commit_rsp : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_COMMIT) |=> (rsp_valid_ff && (state_ff == SEQ_IDLE)))
      else $error("commit did not present its result");

   a_shift_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SHIFT) |-> (step_ff != '0))
      else $error("shift counter exhausted while shifting");

endmodule

// ===== design/indexed_insert_erase_array.sv =====
// Top level of the indexed insert/erase array: one controller and a row of storage cells.
// Depends on ieea_pkg, ieea_ctrl and ieea_cell.
//
//   Port group | Direction | Handshake        | Payload
//   req_       | in        | req_valid/stall  | req_data (op, index, amount, write_value)
//   rsp_       | out       | rsp_valid/stall  | rsp_data (read_value, fill_count, status,
//              |           |                  |           result_position)
//
// Most operations are applied to the cells directly on acceptance: a cell moves by
// at most one position or takes the fill word. Insert copies of n and erase range of n
// entries, when n is one or more, load the transit row, shift it one position per cycle
// and commit it; one item is held at a time then. With n of zero they apply directly.
// Reset clears the count and every stored word at once; there is no clearing pass.
// A stalled result holds off the next item, whatever its operation, until it is taken.
`timescale 1ns / 1ps

module indexed_insert_erase_array (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ieea_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ieea_pkg::rsp_type rsp_data
);
   import ieea_pkg::*;

   cell_ctrl_type cell_ctrl;
   word_type      word_w    [DEPTH];
   word_type      transit_w [DEPTH];
   word_type      lower_w   [DEPTH];
   word_type      upper_w   [DEPTH];
   word_type      lower_t   [DEPTH];
   word_type      upper_t   [DEPTH];

   ieea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cell_word (word_w),
      .cell_ctrl (cell_ctrl)
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign lower_w[g] = '0;
         assign lower_t[g] = '0;
      end else begin : g_mid_lo
         assign lower_w[g] = word_w[g-1];
         assign lower_t[g] = transit_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign upper_w[g] = '0;
         assign upper_t[g] = '0;
      end else begin : g_mid_hi
         assign upper_w[g] = word_w[g+1];
         assign upper_t[g] = transit_w[g+1];
      end

      ieea_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_index    (IDX_BITS'(g)),
         .ctrl          (cell_ctrl),
         .lower_word    (lower_w[g]),
         .upper_word    (upper_w[g]),
         .lower_transit (lower_t[g]),
         .upper_transit (upper_t[g]),
         .word          (word_w[g]),
         .transit       (transit_w[g])
      );
   end

endmodule
